// ===== hdl/topk_categorical_sampler_assert.svh =====
// assertion macros for the top-k sampler
`ifndef TOPK_CATEGORICAL_SAMPLER_ASSERT_SVH
`define TOPK_CATEGORICAL_SAMPLER_ASSERT_SVH
`ifndef SYNTH
// property that holds at every clock edge out of reset
`define TCS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tcs assertion failed");
// condition that never holds out of reset
`define TCS_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tcs assertion failed");
`else
`define TCS_ASSERT(label, clk, rst_n, prop)
`define TCS_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hdl/tcs_pkg.sv =====
`default_nettype none
package tcs_pkg;

    localparam int TOKEN_W  = 12;
    localparam int CHOSEN_W = 15;
    localparam int TOPK_W   = 13;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int U_W      = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOPK_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_K         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RNG_INCREMENT = 2'd3;

    // pcg32 constants
    localparam logic [63:0] PCG_MULT = 64'h5851_F42D_4C95_7F2D;
    localparam int PCG_XS_SHIFT  = 18;
    localparam int PCG_OUT_SHIFT = 27;
    localparam int PCG_ROT_SHIFT = 59;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_TOTAL_ZERO = 2'd1,
        STATUS_TOPK_ZERO  = 2'd2,
        STATUS_OVERFLOW   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MUL_LL  = 2'd0,
        MUL_LH  = 2'd1,
        MUL_HL  = 2'd2,
        MUL_THR = 2'd3
    } mul_phase_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       wr_item;
        logic       rd;
        logic       take_first;
        logic       take_best;
        logic       swap_far;
        logic       swap_near;
        logic       acc_clear;
        logic       acc_add;
        logic       total_load;
        logic       mul_go;
        mul_phase_t mul_phase;
        logic       smp_step;
        logic       res_clear;
        logic       out_load;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic greater;
        logic reached;
        logic total_zero;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/tcs_item_if.sv =====
`default_nettype none
interface tcs_item_if #(
    parameter int WEIGHT_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [WEIGHT_BITS-1:0] weight;
    logic                          is_last;

    modport source (output valid, output weight, output is_last, input ready);
    modport sink   (input valid, input weight, input is_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/tcs_result_if.sv =====
`default_nettype none
interface tcs_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] token_index;
    logic [14:0] chosen_weight;
    logic [1:0]  status;

    modport source (output valid, output token_index, output chosen_weight, output status,
                    input ready);
    modport sink   (input valid, input token_index, input chosen_weight, input status,
                    output ready);
endinterface
`default_nettype wire

// ===== hdl/tcs_datapath.sv =====
`default_nettype none
module tcs_datapath #(
    parameter int MAX_VOCAB   = 4096,
    parameter int WEIGHT_BITS = 16,
    parameter int ADDR_W      = 12
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire logic signed [WEIGHT_BITS-1:0] weight,
    input  wire tcs_pkg::dp_cmd_t           cmd,
    input  wire logic [ADDR_W-1:0]          addr,
    input  wire logic                       cfg_write,
    input  wire logic [tcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tcs_pkg::CFG_W-1:0]  cfg_data,
    output tcs_pkg::dp_stat_t               stat,
    output logic [tcs_pkg::TOKEN_W-1:0]     token_index,
    output logic [tcs_pkg::CHOSEN_W-1:0]    chosen_weight
);
    import tcs_pkg::*;

    localparam int WW    = WEIGHT_BITS - 1;
    localparam int WORD_W = ADDR_W + WW;
    localparam int TOT_W = WW + ADDR_W;
    localparam int THR_W = TOT_W + U_W;

    logic [WORD_W-1:0] mem [MAX_VOCAB];

    logic [WORD_W-1:0] rd_word_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [WORD_W-1:0] best_word_reg;
    logic [ADDR_W-1:0] best_addr_reg;
    logic [WORD_W-1:0] first_word_reg;
    logic [TOT_W-1:0]  acc_reg;
    logic [TOT_W-1:0]  total_reg;
    logic [63:0]       rng_state_reg;
    logic [63:0]       rng_inc_reg;
    logic [63:0]       lo_reg;
    logic [31:0]       cross_reg;
    logic [U_W-1:0]    u_reg;
    logic [THR_W-1:0]  thresh_reg;
    logic [WORD_W-1:0] res_reg;
    logic [TOKEN_W-1:0]  out_token_reg;
    logic [CHOSEN_W-1:0] out_weight_reg;

    logic [WW-1:0]     clamped;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [WW-1:0]     rd_weight;
    logic [WW-1:0]     best_weight;
    logic [TOT_W-1:0]  acc_sum;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       prod;
    logic [31:0]       xs;
    logic [4:0]        rot;
    logic [31:0]       draw;

    // negative weights count as zero
    assign clamped = weight[WEIGHT_BITS-1] ? '0 : weight[WW-1:0];

    // single write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr;
        wr_data = {addr, clamped};
        if (cmd.wr_item)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.swap_far)
        begin
            wr_en   = 1'b1;
            wr_addr = best_addr_reg;
            wr_data = first_word_reg;
        end
        else if (cmd.swap_near)
        begin
            wr_en   = 1'b1;
            wr_data = best_word_reg;
        end
    end

    // entry store, index and weight per word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_word_reg <= mem[addr];
            rd_addr_reg <= addr;
        end
    end

    assign rd_weight   = rd_word_reg[WW-1:0];
    assign best_weight = best_word_reg[WW-1:0];
    assign acc_sum     = acc_reg + TOT_W'(rd_weight);

    assign stat.greater    = rd_weight > best_weight;
    assign stat.reached    = {acc_sum, U_W'(0)} >= thresh_reg;
    assign stat.total_zero = total_reg == '0;

    // shared 32x32 multiplier for the generator step
    always_comb
    begin
        case (cmd.mul_phase)
            MUL_LL:
            begin
                mul_a = rng_state_reg[31:0];
                mul_b = PCG_MULT[31:0];
            end
            MUL_LH:
            begin
                mul_a = rng_state_reg[31:0];
                mul_b = PCG_MULT[63:32];
            end
            MUL_HL:
            begin
                mul_a = rng_state_reg[63:32];
                mul_b = PCG_MULT[31:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = 64'(mul_a) * 64'(mul_b);

    // xsh-rr output of the current state
    assign xs   = 32'(((rng_state_reg >> PCG_XS_SHIFT) ^ rng_state_reg) >> PCG_OUT_SHIFT);
    assign rot  = 5'(rng_state_reg >> PCG_ROT_SHIFT);
    assign draw = (xs >> rot) | (xs << (5'd0 - rot));

    // generator and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rng_state_reg <= '0;
            rng_inc_reg   <= 64'd1;
        end
        else if (cfg_write && cfg_index == CFG_RNG_SEED)
        begin
            rng_state_reg <= cfg_data;
        end
        else if (cfg_write && cfg_index == CFG_RNG_INCREMENT)
        begin
            rng_inc_reg <= cfg_data | 64'd1;
        end
        else if (cmd.mul_go && cmd.mul_phase == MUL_HL)
        begin
            rng_state_reg <= lo_reg + {cross_reg + prod[31:0], 32'd0} + rng_inc_reg;
        end
    end

    // arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
        begin
            case (cmd.mul_phase)
                MUL_LL:  lo_reg <= prod;
                MUL_LH:  cross_reg <= prod[31:0];
                MUL_HL:  u_reg <= draw[31:8];
                MUL_THR: thresh_reg <= THR_W'(u_reg) * THR_W'(total_reg);
                default: lo_reg <= prod;
            endcase
        end
        if (cmd.take_first)
        begin
            first_word_reg <= rd_word_reg;
        end
        if (cmd.take_first || cmd.take_best)
        begin
            best_word_reg <= rd_word_reg;
            best_addr_reg <= rd_addr_reg;
        end
        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_add || cmd.smp_step)
        begin
            acc_reg <= acc_sum;
        end
        if (cmd.total_load)
        begin
            total_reg <= acc_reg;
        end
        if (cmd.res_clear)
        begin
            res_reg <= '0;
        end
        else if (cmd.smp_step && stat.reached)
        begin
            res_reg <= rd_word_reg;
        end
        if (cmd.out_load)
        begin
            out_token_reg  <= TOKEN_W'(res_reg[WORD_W-1:WW]);
            out_weight_reg <= CHOSEN_W'(res_reg[WW-1:0]);
        end
    end

    assign token_index   = out_token_reg;
    assign chosen_weight = out_weight_reg;

endmodule
`default_nettype wire

// ===== hdl/tcs_controller.sv =====
`default_nettype none
`include "topk_categorical_sampler_assert.svh"
module tcs_controller #(
    parameter int MAX_VOCAB = 4096,
    parameter int ADDR_W    = 12,
    parameter int CNT_W     = 13
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_is_last,
    output logic                            in_ready,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [1:0]                      out_status,
    input  wire logic                       cfg_write,
    input  wire logic [tcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tcs_pkg::CFG_W-1:0]  cfg_data,
    input  wire tcs_pkg::dp_stat_t          stat,
    output tcs_pkg::dp_cmd_t                cmd,
    output logic [ADDR_W-1:0]               addr
);
    import tcs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SI_RD, S_SI_TAKE, S_SJ_RD, S_SJ_CMP, S_SWAP_FAR, S_SWAP_NEAR,
        S_SUM_RD, S_SUM_ADD, S_TOTAL, S_TCHK, S_MUL1, S_MUL2, S_THR, S_SMP_RD
    } state_t;

    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_VOCAB);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic              ovf_reg, ovf_next;
    status_t           status_reg, status_next;
    status_t           out_status_reg, out_status_next;
    logic              out_valid_reg, out_valid_next;
    logic              topk_en_reg, topk_en_next;
    logic [TOPK_W-1:0] top_k_reg, top_k_next;
    logic              smp_wait_reg, smp_wait_next;
    logic [CNT_W-1:0]  i_inc;
    logic [CNT_W-1:0]  j_inc;

    assign i_inc = i_reg + CNT_W'(1);
    assign j_inc = j_reg + CNT_W'(1);

    assign in_ready   = state_reg == S_IDLE;
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;

    // next state, counters and datapath commands
    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        ovf_next        = ovf_reg;
        status_next     = status_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg;
        topk_en_next    = topk_en_reg;
        top_k_next      = top_k_reg;
        smp_wait_next   = smp_wait_reg;
        cmd             = '0;
        cmd.mul_phase   = MUL_LL;
        addr            = i_reg[ADDR_W-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg_write && cfg_index == CFG_TOPK_ENABLE)
        begin
            topk_en_next = cfg_data[0];
        end
        if (cfg_write && cfg_index == CFG_TOP_K)
        begin
            top_k_next = cfg_data[TOPK_W-1:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                addr = n_reg[ADDR_W-1:0];
                if (in_valid)
                begin
                    if (n_reg < FULL)
                    begin
                        cmd.wr_item = 1'b1;
                        n_next      = n_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_is_last)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                i_next        = '0;
                cmd.acc_clear = 1'b1;
                if (ovf_reg)
                begin
                    status_next   = STATUS_OVERFLOW;
                    cmd.res_clear = 1'b1;
                    smp_wait_next = 1'b1;
                    state_next    = S_SMP_RD;
                end
                else if (topk_en_reg && top_k_reg == '0)
                begin
                    status_next   = STATUS_TOPK_ZERO;
                    cmd.res_clear = 1'b1;
                    smp_wait_next = 1'b1;
                    state_next    = S_SMP_RD;
                end
                else
                begin
                    status_next = STATUS_OK;
                    if (topk_en_reg && 32'(top_k_reg) < 32'(n_reg))
                    begin
                        k_next = CNT_W'(top_k_reg);
                    end
                    else
                    begin
                        k_next = n_reg;
                    end
                    state_next = topk_en_reg ? S_SI_RD : S_SUM_RD;
                end
            end
            S_SI_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_SI_TAKE;
            end
            S_SI_TAKE:
            begin
                cmd.take_first = 1'b1;
                if (i_inc == n_reg)
                begin
                    i_next     = '0;
                    state_next = S_SUM_RD;
                end
                else
                begin
                    j_next     = i_inc;
                    state_next = S_SJ_RD;
                end
            end
            S_SJ_RD:
            begin
                addr       = j_reg[ADDR_W-1:0];
                cmd.rd     = 1'b1;
                state_next = S_SJ_CMP;
            end
            S_SJ_CMP:
            begin
                cmd.take_best = stat.greater;
                if (j_inc == n_reg)
                begin
                    state_next = S_SWAP_FAR;
                end
                else
                begin
                    j_next     = j_inc;
                    state_next = S_SJ_RD;
                end
            end
            S_SWAP_FAR:
            begin
                cmd.swap_far = 1'b1;
                state_next   = S_SWAP_NEAR;
            end
            S_SWAP_NEAR:
            begin
                cmd.swap_near = 1'b1;
                if (i_inc == k_reg)
                begin
                    i_next     = '0;
                    state_next = S_SUM_RD;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_SI_RD;
                end
            end
            S_SUM_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_SUM_ADD;
            end
            S_SUM_ADD:
            begin
                cmd.acc_add = 1'b1;
                if (i_inc == k_reg)
                begin
                    state_next = S_TOTAL;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_SUM_RD;
                end
            end
            S_TOTAL:
            begin
                cmd.total_load = 1'b1;
                cmd.acc_clear  = 1'b1;
                state_next     = S_TCHK;
            end
            S_TCHK:
            begin
                if (stat.total_zero)
                begin
                    status_next   = STATUS_TOTAL_ZERO;
                    cmd.res_clear = 1'b1;
                    smp_wait_next = 1'b1;
                    state_next    = S_SMP_RD;
                end
                else
                begin
                    cmd.mul_go    = 1'b1;
                    cmd.mul_phase = MUL_LL;
                    state_next    = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul_go    = 1'b1;
                cmd.mul_phase = MUL_LH;
                state_next    = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_go    = 1'b1;
                cmd.mul_phase = MUL_HL;
                state_next    = S_THR;
            end
            S_THR:
            begin
                cmd.mul_go    = 1'b1;
                cmd.mul_phase = MUL_THR;
                i_next        = '0;
                j_next        = '0;
                state_next    = S_SMP_RD;
            end
            S_SMP_RD:
            begin
                // smp_wait set: result ready, wait for the output register
                if (smp_wait_reg)
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        cmd.out_load    = 1'b1;
                        out_valid_next  = 1'b1;
                        out_status_next = status_reg;
                        n_next          = '0;
                        ovf_next        = 1'b0;
                        smp_wait_next   = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
                else if (j_reg == '0)
                begin
                    cmd.rd = 1'b1;
                    j_next = CNT_W'(1);
                end
                else
                begin
                    cmd.smp_step = 1'b1;
                    j_next       = '0;
                    if (stat.reached)
                    begin
                        smp_wait_next = 1'b1;
                    end
                    else
                    begin
                        i_next = i_inc;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            n_reg          <= '0;
            k_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            ovf_reg        <= 1'b0;
            status_reg     <= STATUS_OK;
            out_status_reg <= STATUS_OK;
            out_valid_reg  <= 1'b0;
            topk_en_reg    <= 1'b0;
            top_k_reg      <= TOPK_W'(1);
            smp_wait_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            n_reg          <= n_next;
            k_reg          <= k_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            ovf_reg        <= ovf_next;
            status_reg     <= status_next;
            out_status_reg <= out_status_next;
            out_valid_reg  <= out_valid_next;
            topk_en_reg    <= topk_en_next;
            top_k_reg      <= top_k_next;
            smp_wait_reg   <= smp_wait_next;
        end
    end

    `TCS_ASSERT(a_count_bound, clk, rst_n, n_reg <= FULL)
    `TCS_ASSERT(a_ovf_full, clk, rst_n, ovf_reg |-> n_reg == FULL)
    `TCS_ASSERT(a_scan_range, clk, rst_n, (state_reg == S_SJ_CMP) |-> (j_reg < n_reg && i_reg < k_reg))
    `TCS_ASSERT_NEVER(a_keep_over, clk, rst_n, state_reg == S_SUM_ADD && k_reg > n_reg)

endmodule
`default_nettype wire

// ===== hdl/topk_categorical_sampler.sv =====
// Top-k categorical sampler.
// items channel: one weight per item (signed, negatives count as zero), is_last
// closes the vocabulary. An item is taken in every cycle while the block loads.
// results channel: one result per vocabulary with token_index, chosen_weight and
// status (0 ok, 1 total zero, 2 top_k zero, 3 overflow); error results carry zeros.
// Config port: cfg_write, cfg_index, cfg_data; write while idle. Writing rng_seed
// loads the generator state.
// After is_last, the work is bounded by the single read port of the entry store:
// with top-k on, a selection pass moves the k largest entries to the front,
// then come the sum over the first k entries, the generator step (three 32x32
// products and the threshold product) and the sampling scan.
// New items are held off until the result is placed in the output register.
// Reset clears counters, flags and config to defaults; the entry store needs no
// clearing. A stalled receiver holds the result; the block loads the next
// vocabulary meanwhile and waits at its end until the output register is free.
`default_nettype none
module topk_categorical_sampler #(
    parameter int MAX_VOCAB   = 4096,
    parameter int WEIGHT_BITS = 16
) (
    input  wire                             clk,
    input  wire                             rst_n,
    tcs_item_if.sink                        items,
    tcs_result_if.source                    results,
    input  wire logic                       cfg_write,
    input  wire logic [tcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tcs_pkg::CFG_W-1:0]  cfg_data
);
    import tcs_pkg::*;

    localparam int ADDR_W = $clog2(MAX_VOCAB);
    localparam int CNT_W  = $clog2(MAX_VOCAB + 1);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [ADDR_W-1:0] addr;

    tcs_controller #(
        .MAX_VOCAB (MAX_VOCAB),
        .ADDR_W    (ADDR_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (items.valid),
        .in_is_last (items.is_last),
        .in_ready   (items.ready),
        .out_valid  (results.valid),
        .out_ready  (results.ready),
        .out_status (results.status),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .stat       (stat),
        .cmd        (cmd),
        .addr       (addr)
    );

    tcs_datapath #(
        .MAX_VOCAB   (MAX_VOCAB),
        .WEIGHT_BITS (WEIGHT_BITS),
        .ADDR_W      (ADDR_W)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .weight        (items.weight),
        .cmd           (cmd),
        .addr          (addr),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .stat          (stat),
        .token_index   (results.token_index),
        .chosen_weight (results.chosen_weight)
    );

endmodule
`default_nettype wire

// ===== sim/tb_topk_categorical_sampler.sv =====
`timescale 1ns / 1ps
module tb_topk_categorical_sampler;
    import tcs_pkg::*;

    localparam int VOCAB = 4096;
    localparam logic [63:0] PCG_MUL = 64'd6364136223846793005;

    typedef struct {
        logic [11:0] token;
        logic [14:0] weight;
        status_t     status;
    } draw_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    tcs_item_if #(.WEIGHT_BITS(16)) items_ch();
    tcs_result_if results_ch();

    topk_categorical_sampler #(.MAX_VOCAB(VOCAB), .WEIGHT_BITS(16)) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .items(items_ch.sink),
        .results(results_ch.source),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor copy of the sampler state
    logic [14:0] vocab_w [VOCAB];
    logic [11:0] vocab_idx [VOCAB];
    int          vocab_len = 0;
    bit          vocab_overflow = 0;
    logic [63:0] pcg_state = '0;
    logic [63:0] pcg_inc = 64'd1;
    bit          keep_topk = 0;
    int          keep_count = 1;

    draw_t expected_draws[$];
    int    error_count = 0;
    int    tx_idle_pct = 0;
    int    rx_idle_pct = 0;
    int    rx_hold = 0;

    always #5 clk = ~clk;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // pcg32 xsh-rr word, advances the predictor generator
    function automatic logic [31:0] pcg_next();
        logic [63:0] old;
        logic [31:0] xs;
        logic [4:0]  rot;
        old = pcg_state;
        pcg_state = old * PCG_MUL + (pcg_inc | 64'd1);
        xs = 32'(((old >> 18) ^ old) >> 27);
        rot = old[63:59];
        return (xs >> rot) | (xs << ((32 - rot) & 31));
    endfunction

    // close the vocabulary: top-k, sum, draw, scan
    function automatic draw_t close_vocab();
        draw_t r;
        int k, best;
        logic [14:0] tw;
        logic [11:0] ti;
        logic [63:0] total, acc;
        logic [23:0] u;
        r.token = '0;
        r.weight = '0;
        r.status = STATUS_OK;
        total = '0;
        if (vocab_overflow)
            r.status = STATUS_OVERFLOW;
        else if (keep_topk && keep_count == 0)
            r.status = STATUS_TOPK_ZERO;
        if (r.status == STATUS_OK && keep_topk) begin
            k = (keep_count < vocab_len) ? keep_count : vocab_len;
            for (int i = 0; i < k; i++) begin
                best = i;
                for (int j = i + 1; j < vocab_len; j++)
                    if (vocab_w[j] > vocab_w[best])
                        best = j;
                tw = vocab_w[i];
                ti = vocab_idx[i];
                vocab_w[i] = vocab_w[best];
                vocab_idx[i] = vocab_idx[best];
                vocab_w[best] = tw;
                vocab_idx[best] = ti;
            end
            for (int i = k; i < vocab_len; i++)
                vocab_w[i] = '0;
        end
        if (r.status == STATUS_OK) begin
            for (int i = 0; i < vocab_len; i++)
                total += vocab_w[i];
            if (total == 0)
                r.status = STATUS_TOTAL_ZERO;
        end
        if (r.status == STATUS_OK) begin
            u = pcg_next() >> 8;
            acc = '0;
            r.token = vocab_idx[0];
            r.weight = vocab_w[0];
            for (int i = 0; i < vocab_len; i++) begin
                acc += vocab_w[i];
                if ({acc, 24'd0} >= 88'(u) * 88'(total)) begin
                    r.token = vocab_idx[i];
                    r.weight = vocab_w[i];
                    break;
                end
            end
        end
        vocab_len = 0;
        vocab_overflow = 0;
        return r;
    endfunction

    task automatic stop_items();
        @(negedge clk);
        items_ch.valid = 1'b0;
    endtask

    // stop offering, wait until every expected result has been taken, then let the block settle
    task automatic drain();
        stop_items();
        while (expected_draws.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // register write, only while idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            CFG_TOPK_ENABLE:   keep_topk = value[0];
            CFG_TOP_K:         keep_count = int'(value[12:0]);
            CFG_RNG_SEED:      pcg_state = value;
            CFG_RNG_INCREMENT: pcg_inc = value | 64'd1;
            default: ;
        endcase
    endtask

    task automatic setup(input bit en, input int k, input logic [63:0] seed,
                         input logic [63:0] inc);
        drain();
        write_reg(CFG_TOPK_ENABLE, 64'(en));
        write_reg(CFG_TOP_K, 64'(k));
        write_reg(CFG_RNG_SEED, seed);
        write_reg(CFG_RNG_INCREMENT, inc);
    endtask

    // offer one item and record its effect once accepted
    task automatic send_item(input logic [15:0] w, input bit last);
        @(negedge clk);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            items_ch.valid = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        items_ch.valid = 1'b1;
        items_ch.weight = w;
        items_ch.is_last = last;
        do
            @(posedge clk);
        while (!items_ch.ready);
        if (vocab_len < VOCAB) begin
            vocab_w[vocab_len] = w[15] ? 15'd0 : w[14:0];
            vocab_idx[vocab_len] = 12'(vocab_len);
            vocab_len++;
        end else begin
            vocab_overflow = 1;
        end
        if (last)
            expected_draws.push_back(close_vocab());
    endtask

    function automatic logic [15:0] pick_weight(input int style);
        case (style)
            0: return 16'($urandom);
            1: return 16'($urandom_range(32767));
            2: return ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(40));
            default: return ($urandom_range(1) == 0) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    task automatic send_vocab(input int n, input int style);
        for (int i = 0; i < n; i++)
            send_item(pick_weight(style), i == n - 1);
    endtask

    // result checker
    always @(posedge clk) begin
        draw_t e;
        if (rst_n && results_ch.valid && results_ch.ready) begin
            if (expected_draws.size() == 0) begin
                report("unexpected result", 32'(results_ch.token_index), 0);
            end else begin
                e = expected_draws.pop_front();
                if (results_ch.status !== e.status)
                    report("status", 32'(results_ch.status), 32'(e.status));
                if (results_ch.token_index !== e.token)
                    report("token_index", 32'(results_ch.token_index), 32'(e.token));
                if (results_ch.chosen_weight !== e.weight)
                    report("chosen_weight", 32'(results_ch.chosen_weight), 32'(e.weight));
            end
        end
    end

    // receiver idling and long hold-off
    always @(negedge clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            results_ch.ready <= 1'b0;
        end else begin
            results_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic test_directed();
        // extremes, ties, single entry, error codes
        setup(0, 1, 64'd0, 64'd1);
        send_item(16'h7fff, 1);
        send_item(16'h8000, 1);
        send_item(16'hffff, 0);
        send_item(16'h0000, 1);
        send_vocab(4, 3);
        setup(1, 0, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        send_vocab(3, 1);
        drain();
        setup(1, 2, 64'h1234_5678_9abc_def0, 64'd0);
        send_item(16'd5, 0);
        send_item(16'd9, 0);
        send_item(16'd9, 0);
        send_item(16'd9, 1);
        send_item(16'd0, 0);
        send_item(16'h8001, 1);
        drain();
        setup(1, 4096, 64'd7, 64'd54);
        send_vocab(5, 1);
        send_vocab(1, 1);
        drain();
    endtask

    task automatic test_random(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
            send_vocab(len, $urandom_range(3));
            sent += len;
        end
        stop_items();
        drain();
    endtask

    task automatic test_backpressure();
        setup(1, 2, 64'hdead_beef, 64'd11);
        rx_hold = 400;
        for (int v = 0; v < 6; v++)
            send_vocab($urandom_range(8, 2), 1);
        stop_items();
        drain();
    endtask

    task automatic random_setup();
        int k;
        case ($urandom_range(3))
            0: k = 0;
            1: k = 1;
            2: k = 4096;
            default: k = $urandom_range(8191);
        endcase
        setup($urandom_range(1), k, {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    initial begin
        items_ch.valid = 1'b0;
        items_ch.weight = '0;
        items_ch.is_last = 1'b0;
        results_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        tx_idle_pct = 34;
        rx_idle_pct = 85;
        for (int p = 0; p < 3; p++)
        begin
            random_setup();
            test_random(120);
        end
        tx_idle_pct = 85;
        rx_idle_pct = 34;
        for (int p = 0; p < 3; p++)
        begin
            random_setup();
            test_random(120);
        end
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int p = 0; p < 3; p++)
        begin
            random_setup();
            test_random(120);
        end
        drain();
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tcs_pkg.sv
hdl/tcs_item_if.sv
hdl/tcs_result_if.sv
hdl/tcs_datapath.sv
hdl/tcs_controller.sv
hdl/topk_categorical_sampler.sv
sim/tb_topk_categorical_sampler.sv
